FILE: hdl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

FILE: hdl/cths_pkg.sv
// package: constants and types of the crypt table string hash
package cths_pkg;

    localparam int HASH_TYPES_DEF = 5;
    localparam int ROW_SIZE       = 256;
    localparam int CHAR_W         = 8;
    localparam int HASH_W         = 32;
    localparam int TYPE_W         = 3;
    localparam int LCG_W          = 22;
    localparam int PROD_W         = 29;
    localparam int QUOT_W         = 7;
    localparam int REM_W          = 23;
    localparam int RECIP_W        = 11;
    localparam int HALF_W         = 16;

    localparam logic [LCG_W-1:0]   LCG_START = 22'h100001;
    localparam logic [QUOT_W-1:0]  LCG_MUL   = 7'd125;
    localparam logic [LCG_W-1:0]   LCG_MOD   = 22'h2AAAAB;
    // floor(2^32 / LCG_MOD), estimate is low by at most one
    localparam logic [RECIP_W-1:0] LCG_RECIP = 11'd1535;
    localparam int                 RECIP_SHIFT = 32;

    localparam logic [HASH_W-1:0] SEED_ONE_START = 32'h7FED7FED;
    localparam logic [HASH_W-1:0] SEED_TWO_START = 32'hEEEEEEEE;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic ADDR_HASH_TYPE = 1'b0;

    typedef enum logic [2:0] {
        FILL_MUL,
        FILL_QEST,
        FILL_REM,
        FILL_FIX,
        FILL_DONE
    } fill_state_t;

endpackage

FILE: hdl/crypt_table_string_hash_top.sv
// top level: streaming string hash over a crypt table
//
// the slave stream takes one key byte per transfer in s_tdata, with s_tlast
// on the final byte of the string. when the final byte has been hashed, the
// 32-bit hash appears as one transfer on the master stream (m_tdata).
// the hash type register (apb, address 0) selects the crypt table row;
// values of HASH_TYPES or more use the last row. write it only while idle.
// throughput: one byte per cycle while no final byte waits on the output,
// set by the single table read port and the seed update that follows it.
// a last byte goes through the read stage, then its hash sets m_tvalid_reg.
// reset: seeds go to their start values and the lcg sequencer fills the
// crypt table, each word from a high-half then a low-half lcg step (mul,
// q estimate, remainder, fix); s_tready stays low until the fill is done.
// stall: with m_tready low the held result stays; non-final bytes still
// flow, and a final byte waits in the read stage until the output frees.
module crypt_table_string_hash_top
    import cths_pkg::*;
#(
    parameter int HASH_TYPES = HASH_TYPES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // char_code[7:0]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [HASH_W-1:0] m_tdata,   // hash_value[31:0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int TABLE_DEPTH = ROW_SIZE * HASH_TYPES;
    localparam int AW          = $clog2(TABLE_DEPTH);

    // configuration
    logic [TYPE_W-1:0] hash_type_reg;
    logic [TYPE_W-1:0] hash_row;

    // fill sequencer
    fill_state_t        fill_state_reg, fill_state_next;
    logic [LCG_W-1:0]   lcg_reg, lcg_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               half_reg, half_next;
    logic [HALF_W-1:0]  hi_reg, hi_next;
    logic [TYPE_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [CHAR_W-1:0]  col_cnt_reg, col_cnt_next;
    logic               fill_last;
    logic [PROD_W+RECIP_W-1:0] qest_wide;
    logic [LCG_W-1:0]   lcg_reduced;
    logic               ram_we;
    logic               table_ready;

    // hash pipeline
    logic               st1_valid_reg, st1_valid_next;
    logic [CHAR_W-1:0]  st1_char_reg, st1_char_next;
    logic               st1_last_reg, st1_last_next;
    logic [HASH_W-1:0]  first_seed_reg, first_seed_next;
    logic [HASH_W-1:0]  second_seed_reg, second_seed_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [HASH_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [HASH_W-1:0]  table_word;
    logic [HASH_W-1:0]  first_new;
    logic [HASH_W-1:0]  second_new;
    logic               st1_fire;
    logic               advance;
    logic               in_accept;
    logic [AW-1:0]      rd_addr;
    logic               last_held;
    logic               last_done;
    logic               seeds_at_start;

    // apb register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_type_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_HASH_TYPE))
        begin
            hash_type_reg <= pwdata[TYPE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_HASH_TYPE)
        begin
            prdata = APB_DW'(hash_type_reg);
        end
    end

    // table memory
    cths_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'({row_cnt_reg, col_cnt_reg})),
        .wdata ({hi_reg, lcg_reduced[HALF_W-1:0]}),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (table_word)
    );

    // fill sequencer: x = s*125+3, q estimate, remainder, final correction
    assign fill_last   = (row_cnt_reg == TYPE_W'(HASH_TYPES - 1)) &&
                         (col_cnt_reg == {CHAR_W{1'b1}});
    assign qest_wide   = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(LCG_RECIP);
    assign lcg_reduced = (rem_reg >= REM_W'(LCG_MOD)) ? LCG_W'(rem_reg - REM_W'(LCG_MOD))
                                                      : LCG_W'(rem_reg);

    always_comb
    begin
        fill_state_next = fill_state_reg;
        unique case (fill_state_reg)
            FILL_MUL:  fill_state_next = FILL_QEST;
            FILL_QEST: fill_state_next = FILL_REM;
            FILL_REM:  fill_state_next = FILL_FIX;
            FILL_FIX:  fill_state_next = (half_reg && fill_last) ? FILL_DONE : FILL_MUL;
            FILL_DONE: fill_state_next = FILL_DONE;
            default:   fill_state_next = FILL_DONE;
        endcase
    end

    always_comb
    begin
        ram_we      = 1'b0;
        table_ready = 1'b0;
        unique case (fill_state_reg)
            FILL_FIX:  ram_we = half_reg;
            FILL_DONE: table_ready = 1'b1;
            default:   ram_we = 1'b0;
        endcase
    end

    always_comb
    begin
        lcg_next     = lcg_reg;
        prod_next    = PROD_W'(lcg_reg * LCG_MUL + 3);
        quot_next    = QUOT_W'(qest_wide >> RECIP_SHIFT);
        rem_next     = REM_W'(prod_reg - PROD_W'(quot_reg) * PROD_W'(LCG_MOD));
        half_next    = half_reg;
        hi_next      = hi_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (fill_state_reg == FILL_FIX)
        begin
            lcg_next  = lcg_reduced;
            half_next = !half_reg;
            if (!half_reg)
            begin
                hi_next = lcg_reduced[HALF_W-1:0];
            end
            else if (row_cnt_reg == TYPE_W'(HASH_TYPES - 1))
            begin
                row_cnt_next = '0;
                col_cnt_next = col_cnt_reg + 1'b1;
            end
            else
            begin
                row_cnt_next = row_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_state_reg <= FILL_MUL;
            lcg_reg        <= LCG_START;
            half_reg       <= 1'b0;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
        end
        else
        begin
            fill_state_reg <= fill_state_next;
            lcg_reg        <= lcg_next;
            half_reg       <= half_next;
            row_cnt_reg    <= row_cnt_next;
            col_cnt_reg    <= col_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        hi_reg   <= hi_next;
    end

    // hash pipeline: read stage then seed update into the seed registers, and on the last byte into the output register
    assign hash_row  = (hash_type_reg >= TYPE_W'(HASH_TYPES)) ? TYPE_W'(HASH_TYPES - 1)
                                                            : hash_type_reg;
    assign rd_addr   = AW'({hash_row, s_tdata});
    assign st1_fire  = st1_valid_reg && (!st1_last_reg || !m_tvalid_reg || m_tready);
    assign advance   = !st1_valid_reg || st1_fire;
    assign s_tready  = table_ready && advance;
    assign in_accept = s_tvalid && s_tready;

    assign first_new  = table_word ^ (first_seed_reg + second_seed_reg);
    assign second_new = HASH_W'(st1_char_reg) + first_new + second_seed_reg +
                        (second_seed_reg << 5) + HASH_W'(3);

    always_comb
    begin
        st1_valid_next   = st1_valid_reg;
        st1_char_next    = st1_char_reg;
        st1_last_next    = st1_last_reg;
        first_seed_next  = first_seed_reg;
        second_seed_next = second_seed_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        if (advance)
        begin
            st1_valid_next = in_accept;
            st1_char_next  = s_tdata;
            st1_last_next  = s_tlast;
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (st1_fire)
        begin
            if (st1_last_reg)
            begin
                first_seed_next  = SEED_ONE_START;
                second_seed_next = SEED_TWO_START;
                m_tvalid_next    = 1'b1;
                m_tdata_next     = first_new;
            end
            else
            begin
                first_seed_next  = first_new;
                second_seed_next = second_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg   <= 1'b0;
            first_seed_reg  <= SEED_ONE_START;
            second_seed_reg <= SEED_TWO_START;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            st1_valid_reg   <= st1_valid_next;
            first_seed_reg  <= first_seed_next;
            second_seed_reg <= second_seed_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_char_reg <= st1_char_next;
        st1_last_reg <= st1_last_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign last_held      = st1_valid_reg && st1_last_reg && !st1_fire;
    assign last_done      = st1_fire && st1_last_reg;
    assign seeds_at_start = (first_seed_reg == SEED_ONE_START) &&
                            (second_seed_reg == SEED_TWO_START);

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_no_write_while_hashing, clk, rst_n, ram_we && st1_valid_reg)
    `ASSERT_CLK(a_ready_stays, clk, rst_n, table_ready |=> table_ready)
    `ASSERT_CLK(a_last_waits_on_output, clk, rst_n, last_held |-> m_tvalid_reg)
    `ASSERT_CLK(a_seeds_restart, clk, rst_n, last_done |=> seeds_at_start)

endmodule

FILE: hdl/cths_ram.sv
// generic single-clock ram, one write port, one registered read port
module cths_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1280
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
